### src/dhpd_pkg.sv
// ----------------------------------------------------------------------------
// dhpd_pkg
// Shared types and constants for the dual Hall position decoder: the step
// direction code, the commutation transition table and per-motor flags.
// ----------------------------------------------------------------------------
package dhpd_pkg;

    // Width of the pin fields and of the decoded Hall code.
    localparam int HALL_WIDTH   = 3;
    // Width of every field of a result item.
    localparam int RESULT_WIDTH = 32;

    typedef logic [HALL_WIDTH-1:0] hall_code_t;

    // Direction of one commutation step.
    typedef enum logic [1:0] {
        STEP_NONE,
        STEP_FWD,
        STEP_REV
    } step_t;

    // Transition table, indexed by previous code and then by new code.
    // Code zero and code seven are invalid patterns and never give a step.
    localparam step_t STEP_TABLE [0:7][0:7] = '{
        '{STEP_NONE, STEP_NONE, STEP_NONE, STEP_NONE,
          STEP_NONE, STEP_NONE, STEP_NONE, STEP_NONE},
        '{STEP_NONE, STEP_NONE, STEP_NONE, STEP_REV,
          STEP_NONE, STEP_FWD,  STEP_NONE, STEP_NONE},
        '{STEP_NONE, STEP_NONE, STEP_NONE, STEP_FWD,
          STEP_NONE, STEP_NONE, STEP_REV,  STEP_NONE},
        '{STEP_NONE, STEP_FWD,  STEP_REV,  STEP_NONE,
          STEP_NONE, STEP_NONE, STEP_NONE, STEP_NONE},
        '{STEP_NONE, STEP_NONE, STEP_NONE, STEP_NONE,
          STEP_NONE, STEP_REV,  STEP_FWD,  STEP_NONE},
        '{STEP_NONE, STEP_REV,  STEP_NONE, STEP_NONE,
          STEP_FWD,  STEP_NONE, STEP_NONE, STEP_NONE},
        '{STEP_NONE, STEP_NONE, STEP_FWD,  STEP_NONE,
          STEP_REV,  STEP_NONE, STEP_NONE, STEP_NONE},
        '{STEP_NONE, STEP_NONE, STEP_NONE, STEP_NONE,
          STEP_NONE, STEP_NONE, STEP_NONE, STEP_NONE}
    };

    // Status reported by one motor tracker for the item being retired.
    typedef struct packed {
        logic  skipped;
        step_t dir;
    } motor_flags_t;

endpackage

### src/dhpd_sample_if.sv
// ----------------------------------------------------------------------------
// dhpd_sample_if
// Channel carrying one sample of both motors' raw Hall pin levels.
// ----------------------------------------------------------------------------
interface dhpd_sample_if;

    logic       valid;
    logic       ready;
    logic [2:0] left_pins;
    logic [2:0] right_pins;

    modport source (
        output valid,
        output left_pins,
        output right_pins,
        input  ready
    );

    modport sink (
        input  valid,
        input  left_pins,
        input  right_pins,
        output ready
    );

endinterface

### src/dhpd_result_if.sv
// ----------------------------------------------------------------------------
// dhpd_result_if
// Channel carrying both wheel positions and the skipped edge count.
// ----------------------------------------------------------------------------
interface dhpd_result_if;

    logic               valid;
    logic               ready;
    logic signed [31:0] left_position;
    logic signed [31:0] right_position;
    logic        [31:0] skipped_edges;

    modport source (
        output valid,
        output left_position,
        output right_position,
        output skipped_edges,
        input  ready
    );

    modport sink (
        input  valid,
        input  left_position,
        input  right_position,
        input  skipped_edges,
        output ready
    );

endinterface

### src/dhpd_motor_track.sv
// ----------------------------------------------------------------------------
// dhpd_motor_track
// Per-motor tracker: decodes the Hall code, looks up the step direction and
// keeps the previous code and the wrapping position accumulator.
// ----------------------------------------------------------------------------
module dhpd_motor_track
    import dhpd_pkg::*;
#(
    parameter int POSITION_WIDTH = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      enable,
    input  logic [HALL_WIDTH-1:0]     pins,
    output logic [POSITION_WIDTH-1:0] position_next,
    output motor_flags_t              flags
);

    hall_code_t                prev_code_reg;
    hall_code_t                code;
    logic [POSITION_WIDTH-1:0] accum_reg;
    logic [POSITION_WIDTH-1:0] delta;
    step_t                     dir;

    // Pins are active low.
    assign code = ~pins;
    assign dir  = STEP_TABLE[prev_code_reg][code];

    // Minus one is all ones, plus one is a single low bit.
    assign delta = (dir == STEP_REV) ? {POSITION_WIDTH{1'b1}}
                                     : POSITION_WIDTH'(1);

    assign position_next = (dir == STEP_NONE) ? accum_reg : accum_reg + delta;

    assign flags.dir     = dir;
    assign flags.skipped = (dir == STEP_NONE) && (prev_code_reg != '0)
                           && (prev_code_reg != code);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_code_reg <= '0;
            accum_reg     <= '0;
        end
        else if (enable)
        begin
            prev_code_reg <= code;
            accum_reg     <= position_next;
        end
    end

endmodule

### src/dual_hall_position_decoder.sv
// ----------------------------------------------------------------------------
// dual_hall_position_decoder
// Wheel position decoder for two motors with three Hall sensors each.
//
// Each input item is one sample of both motors' active-low Hall pins. The
// block decodes each motor's pins into a commutation code, looks up the
// step (back, none or forward) from the previous and new code, and adds it
// to that motor's wrapping signed position. A change of code that is not a
// legal single step from a previous code other than zero bumps a shared
// skipped edge counter, which can rise by two for one item. Every input
// item gives one result item with both positions (low 32 bits) and the skip
// count as they stand after that item. The block takes one item per cycle
// while results are taken; an item waits in the input register, where the
// table lookup and the increment of each accumulator happen, and then moves
// to the result register. The input register is refilled while a finished
// result waits to be taken, so one stalled result does not hold off the
// next item.
// ----------------------------------------------------------------------------
module dual_hall_position_decoder
    import dhpd_pkg::*;
#(
    parameter int POSITION_WIDTH = 32
)
(
    input  logic          clk,
    input  logic          rst_n,
    dhpd_sample_if.sink   sample,
    dhpd_result_if.source result
);

    // Input register stage.
    logic                  in_valid_reg;
    logic [HALL_WIDTH-1:0] left_pins_reg;
    logic [HALL_WIDTH-1:0] right_pins_reg;

    // Result register stage.
    logic                    out_valid_reg;
    logic [RESULT_WIDTH-1:0] left_pos_reg;
    logic [RESULT_WIDTH-1:0] right_pos_reg;
    logic [RESULT_WIDTH-1:0] skip_count_reg;
    logic [RESULT_WIDTH-1:0] skip_count_next;

    logic                      retire;
    logic                      sample_take;
    logic [POSITION_WIDTH-1:0] left_next;
    logic [POSITION_WIDTH-1:0] right_next;
    logic [RESULT_WIDTH-1:0]   left_low;
    logic [RESULT_WIDTH-1:0]   right_low;
    motor_flags_t              left_flags;
    motor_flags_t              right_flags;

    // The item in the input register moves on when the result register is
    // empty or being emptied in this cycle. Tracker state, positions and skip count advance only then.
    assign retire       = in_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !in_valid_reg || retire;
    assign sample_take  = sample.valid && sample.ready;

    dhpd_motor_track #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_left (
        .clk           (clk),
        .rst_n         (rst_n),
        .enable        (retire),
        .pins          (left_pins_reg),
        .position_next (left_next),
        .flags         (left_flags)
    );

    dhpd_motor_track #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_right (
        .clk           (clk),
        .rst_n         (rst_n),
        .enable        (retire),
        .pins          (right_pins_reg),
        .position_next (right_next),
        .flags         (right_flags)
    );

    // The reported position is the low 32 bits of the accumulator; a
    // narrower accumulator is zero extended, as its value is unsigned there.
    generate
        if (POSITION_WIDTH >= RESULT_WIDTH)
        begin : g_pos_trunc
            assign left_low  = left_next[RESULT_WIDTH-1:0];
            assign right_low = right_next[RESULT_WIDTH-1:0];
        end
        else
        begin : g_pos_ext
            assign left_low  = {{(RESULT_WIDTH-POSITION_WIDTH){1'b0}}, left_next};
            assign right_low = {{(RESULT_WIDTH-POSITION_WIDTH){1'b0}}, right_next};
        end
    endgenerate

    // Both motors may report a skipped edge for the same item.
    assign skip_count_next = skip_count_reg
                             + RESULT_WIDTH'(left_flags.skipped)
                             + RESULT_WIDTH'(right_flags.skipped);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            skip_count_reg <= '0;
        end
        else
        begin
            if (sample.ready)
            begin
                in_valid_reg <= sample.valid;
            end
            if (retire)
            begin
                out_valid_reg  <= 1'b1;
                skip_count_reg <= skip_count_next;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (sample_take)
        begin
            left_pins_reg  <= sample.left_pins;
            right_pins_reg <= sample.right_pins;
        end
        if (retire)
        begin
            left_pos_reg  <= left_low;
            right_pos_reg <= right_low;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.left_position  = $signed(left_pos_reg);
    assign result.right_position = $signed(right_pos_reg);
    assign result.skipped_edges  = skip_count_reg;

endmodule
